// ===== rtl/bba_pkg.sv =====
// Shared types, constants and codes of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int NUM_UNITS   = 1024;
	localparam int CACHE_DEPTH = 8;
	localparam int ADDR_W      = 48;
	localparam int IDX_W       = $clog2(NUM_UNITS);
	localparam int CNT_W       = 11;
	localparam int SHIFT_W     = 5;
	localparam int CC_W        = $clog2(CACHE_DEPTH + 1);
	localparam int WORD_W      = 8;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int NUM_WORDS   = NUM_UNITS / WORD_W;
	localparam int WIDX_W      = $clog2(NUM_WORDS);
	localparam int POS_W       = CNT_W + 1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_COUNT = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_NOT_IN    = 3'd3;
	localparam logic [2:0] ST_DOUBLE    = 3'd4;

	localparam logic [1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [1:0] REG_UNIT_SHIFT = 2'd1;
	localparam logic [1:0] REG_UNIT_COUNT = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [CNT_W-1:0]  block_count;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [2:0]        status;
		logic [CNT_W-1:0]  free_errors;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pool_base;
		logic [SHIFT_W-1:0] unit_shift;
		logic [CNT_W-1:0]   units;
	} cfg_t;

	typedef enum logic [1:0] {
		CK_BAD,
		CK_ALLOC,
		CK_FREE,
		CK_NOT_IN
	} cmd_kind_e;

	typedef struct packed {
		cmd_kind_e        kind;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef enum logic [2:0] {
		ES_IDLE,
		ES_SCAN,
		ES_RMW_RD,
		ES_RMW_WR,
		ES_DONE
	} eng_state_e;

endpackage
`default_nettype wire

// ===== rtl/bba_front.sv =====
// Request intake: range and count classification and a two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module bba_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bba_pkg::cfg_t cfg,
	input  wire logic          push,
	output logic               full,
	input  wire bba_pkg::req_t req,
	output logic               cmd_vld,
	output bba_pkg::cmd_t      cmd,
	input  wire logic          cmd_pop
);

	logic [bba_pkg::ADDR_W:0]     diff;
	logic [bba_pkg::ADDR_W-1:0]   span;
	logic [bba_pkg::ADDR_W-1:0]   align;
	logic [bba_pkg::ADDR_W-1:0]   offs;
	logic                         not_in;
	bba_pkg::cmd_t                cls;
	bba_pkg::cmd_t                q_q [2];
	logic                         wp_q, rp_q;
	logic [1:0]                   cnt_q;
	logic                         wr_en;

	always_comb begin
		diff   = {1'b0, req.address} - {1'b0, cfg.pool_base};
		offs   = diff[bba_pkg::ADDR_W-1:0];
		span   = bba_pkg::ADDR_W'(cfg.units) << cfg.unit_shift;
		align  = (bba_pkg::ADDR_W'(1) << cfg.unit_shift) - bba_pkg::ADDR_W'(1);
		not_in = diff[bba_pkg::ADDR_W] || (offs >= span) || ((req.address & align) != '0);
		cls.count = req.block_count;
		cls.idx   = bba_pkg::IDX_W'(offs >> cfg.unit_shift);
		if (req.block_count == '0) begin
			cls.kind = bba_pkg::CK_BAD;
		end else if (req.req_type == bba_pkg::REQ_ALLOC) begin
			cls.kind = bba_pkg::CK_ALLOC;
		end else if (not_in) begin
			cls.kind = bba_pkg::CK_NOT_IN;
		end else begin
			cls.kind = bba_pkg::CK_FREE;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign wr_en   = push && !full;
	assign cmd_vld = (cnt_q != 2'd0);
	assign cmd     = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr_en) - 2'(cmd_pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bba_engine.sv =====
// Allocation engine: freed-unit stack, bitmap memory, run search and result register.
`timescale 1ns / 1ps
`default_nettype none
module bba_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bba_pkg::cfg_t cfg,
	input  wire logic          cmd_vld,
	input  wire bba_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               empty,
	input  wire logic          pop,
	output bba_pkg::rsp_t      rsp
);

	localparam int W = bba_pkg::WORD_W;

	bba_pkg::eng_state_e state_q, state_d;

	logic [W-1:0]                  mem [bba_pkg::NUM_WORDS];
	logic [bba_pkg::NUM_WORDS-1:0] vld_q;
	logic [W-1:0]                  word_q;
	logic                          word_vld_q;
	logic                          rd_en;
	logic [bba_pkg::WIDX_W-1:0]    rd_addr;
	logic                          wr_en;
	logic [W-1:0]                  wr_data;

	logic [bba_pkg::IDX_W-1:0]     cache_q [bba_pkg::CACHE_DEPTH];
	logic [bba_pkg::CC_W-1:0]      cache_cnt_q, cache_cnt_d;
	logic                          cache_push;

	logic [bba_pkg::WIDX_W-1:0]    cur_q, cur_d;
	logic [bba_pkg::CNT_W-1:0]     run_q, run_d;
	logic [bba_pkg::CNT_W-1:0]     n_q, n_d;
	logic [bba_pkg::POS_W-1:0]     lo_q, lo_d, hi_q, hi_d;
	logic                          is_free_q, is_free_d;
	logic [2:0]                    st_q, st_d;
	logic [bba_pkg::CNT_W-1:0]     errs_q, errs_d;
	logic [bba_pkg::IDX_W-1:0]     ridx_q, ridx_d;
	logic                          aen_q, aen_d;

	bba_pkg::rsp_t                 out_q;
	logic                          out_vld_q;
	logic                          load;

	logic [W-1:0]                  eff;
	logic [bba_pkg::CNT_W-1:0]     run;
	logic                          found;
	logic [bba_pkg::CNT_W-1:0]     fstart;
	logic [bba_pkg::POS_W-1:0]     gi;
	logic [bba_pkg::POS_W-1:0]     gw;
	logic [bba_pkg::CNT_W-1:0]     werr;
	logic [bba_pkg::POS_W-1:0]     nxt_start;
	logic [bba_pkg::POS_W-1:0]     lim;
	logic [bba_pkg::POS_W-1:0]     units_x;
	logic [bba_pkg::POS_W-1:0]     tail;
	logic [bba_pkg::CNT_W-1:0]     errs_tot;
	logic [bba_pkg::ADDR_W-1:0]    res_addr;
	logic [bba_pkg::CC_W-1:0]      top_idx;

	assign eff       = word_vld_q ? word_q : '0;
	assign units_x   = bba_pkg::POS_W'(cfg.units);
	assign nxt_start = bba_pkg::POS_W'({cur_q, {bba_pkg::BIT_W{1'b0}}}) + bba_pkg::POS_W'(W);
	assign lim       = (hi_q < units_x) ? hi_q : units_x;
	assign tail      = (hi_q > units_x) ? (hi_q - units_x) : '0;
	assign top_idx   = cache_cnt_q - bba_pkg::CC_W'(1);
	assign res_addr  = aen_q ? (cfg.pool_base +
		(bba_pkg::ADDR_W'(ridx_q) << cfg.unit_shift)) : '0;

	always_comb begin
		run    = run_q;
		found  = 1'b0;
		fstart = '0;
		gi     = '0;
		for (int b = 0; b < W; b++) begin
			gi = bba_pkg::POS_W'({cur_q, bba_pkg::BIT_W'(b)});
			if (gi < units_x && !found) begin
				run = eff[b] ? '0 : run + bba_pkg::CNT_W'(1);
				if (run == n_q) begin
					found  = 1'b1;
					fstart = bba_pkg::CNT_W'(gi) + bba_pkg::CNT_W'(1) - n_q;
				end
			end
		end
	end

	always_comb begin
		wr_data = eff;
		werr    = '0;
		gw      = '0;
		for (int b = 0; b < W; b++) begin
			gw = bba_pkg::POS_W'({cur_q, bba_pkg::BIT_W'(b)});
			if (gw >= lo_q && gw < hi_q && gw < units_x) begin
				if (is_free_q) begin
					if (!eff[b]) begin
						werr = werr + bba_pkg::CNT_W'(1);
					end else begin
						wr_data[b] = 1'b0;
					end
				end else begin
					wr_data[b] = 1'b1;
				end
			end
		end
	end

	assign errs_tot = errs_q + werr + bba_pkg::CNT_W'(tail);

	always_comb begin
		state_d     = state_q;
		cur_d       = cur_q;
		run_d       = run_q;
		n_d         = n_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		is_free_d   = is_free_q;
		st_d        = st_q;
		errs_d      = errs_q;
		ridx_d      = ridx_q;
		aen_d       = aen_q;
		cache_cnt_d = cache_cnt_q;
		cache_push  = 1'b0;
		cmd_pop     = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cur_q;
		wr_en       = 1'b0;
		load        = 1'b0;
		unique case (state_q)
			bba_pkg::ES_IDLE: begin
				if (cmd_vld) begin
					cmd_pop = 1'b1;
					st_d    = bba_pkg::ST_OK;
					errs_d  = '0;
					aen_d   = 1'b0;
					n_d     = cmd.count;
					state_d = bba_pkg::ES_DONE;
					unique case (cmd.kind)
						bba_pkg::CK_BAD: begin
							st_d = bba_pkg::ST_BAD_COUNT;
						end
						bba_pkg::CK_NOT_IN: begin
							st_d   = bba_pkg::ST_NOT_IN;
							errs_d = bba_pkg::CNT_W'(1);
						end
						bba_pkg::CK_ALLOC: begin
							is_free_d = 1'b0;
							if (cmd.count == bba_pkg::CNT_W'(1) && cache_cnt_q != '0) begin
								cache_cnt_d = top_idx;
								ridx_d      = cache_q[top_idx[bba_pkg::CC_W-2:0]];
								aen_d       = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								cur_d   = '0;
								run_d   = '0;
								state_d = bba_pkg::ES_SCAN;
							end
						end
						bba_pkg::CK_FREE: begin
							is_free_d = 1'b1;
							if (cmd.count == bba_pkg::CNT_W'(1) &&
							    cache_cnt_q <= bba_pkg::CC_W'(bba_pkg::CACHE_DEPTH - 2)) begin
								cache_push  = 1'b1;
								cache_cnt_d = cache_cnt_q + bba_pkg::CC_W'(1);
							end else begin
								lo_d    = bba_pkg::POS_W'(cmd.idx);
								hi_d    = bba_pkg::POS_W'(cmd.idx) + bba_pkg::POS_W'(cmd.count);
								cur_d   = cmd.idx[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
								state_d = bba_pkg::ES_RMW_RD;
							end
						end
						default: begin
							st_d = bba_pkg::ST_BAD_COUNT;
						end
					endcase
				end
			end
			bba_pkg::ES_SCAN: begin
				if (found) begin
					lo_d    = bba_pkg::POS_W'(fstart);
					hi_d    = bba_pkg::POS_W'(fstart) + bba_pkg::POS_W'(n_q);
					cur_d   = fstart[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
					state_d = bba_pkg::ES_RMW_RD;
				end else if (nxt_start >= units_x) begin
					st_d    = bba_pkg::ST_FULL;
					state_d = bba_pkg::ES_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_q + bba_pkg::WIDX_W'(1);
					cur_d   = cur_q + bba_pkg::WIDX_W'(1);
					run_d   = run;
				end
			end
			bba_pkg::ES_RMW_RD: begin
				rd_en   = 1'b1;
				state_d = bba_pkg::ES_RMW_WR;
			end
			bba_pkg::ES_RMW_WR: begin
				wr_en  = 1'b1;
				errs_d = errs_q + werr;
				if (nxt_start < lim) begin
					cur_d   = cur_q + bba_pkg::WIDX_W'(1);
					state_d = bba_pkg::ES_RMW_RD;
				end else begin
					state_d = bba_pkg::ES_DONE;
					if (is_free_q) begin
						errs_d = errs_tot;
						st_d   = (errs_tot != '0) ? bba_pkg::ST_DOUBLE : bba_pkg::ST_OK;
					end else begin
						aen_d  = 1'b1;
						ridx_d = lo_q[bba_pkg::IDX_W-1:0];
					end
				end
			end
			bba_pkg::ES_DONE: begin
				if (!out_vld_q || pop) begin
					load    = 1'b1;
					state_d = bba_pkg::ES_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::ES_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			word_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[cur_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cache_push) begin
			cache_q[cache_cnt_q[bba_pkg::CC_W-2:0]] <= cmd.idx;
		end
		cur_q     <= cur_d;
		run_q     <= run_d;
		n_q       <= n_d;
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		is_free_q <= is_free_d;
		st_q      <= st_d;
		errs_q    <= errs_d;
		ridx_q    <= ridx_d;
		aen_q     <= aen_d;
		if (load) begin
			out_q.result_address <= res_addr;
			out_q.status         <= st_q;
			out_q.free_errors    <= errs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::ES_IDLE;
			vld_q       <= '0;
			word_vld_q  <= 1'b0;
			cache_cnt_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			cache_cnt_q <= cache_cnt_d;
			if (rd_en) begin
				word_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[cur_q] <= 1'b1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign empty = !out_vld_q;
	assign rsp   = out_q;

endmodule
`default_nettype wire

// ===== rtl/bitmap_block_allocator_core.sv =====
// Top level of the bitmap block allocator: configuration registers and the two halves.
`timescale 1ns / 1ps
`default_nettype none
// The block hands out and takes back runs of fixed-size units of a memory pool.
// Requests enter through a queue-like port: a transfer happens on a clock edge
// with push high and full low. Results leave the same way: while empty is low
// the oldest result sits on rsp, and a transfer happens when pop is high.
// Every request gives exactly one result, in request order.
// The front classifies each request (zero count, out-of-pool free) and holds
// up to two commands, so requests keep flowing while the engine is busy or a
// result waits. The engine owns the freed-unit stack and the bitmap, kept as a
// memory of 128 eight-bit words with one read or write port.
// A cached, rejected or stack-pushed request passes from the command queue
// through the engine's idle and done states into the result register. An
// allocation scans the bitmap at one word per cycle, then marks its run by
// reading and then writing each word on the single memory port, as does a free.
// The engine works on one request at a time, so a new request starts only after
// the previous result is loaded.
// Reset clears the bitmap at once through per-word valid bits, empties the
// stack and all queues, and loads pool_base 0, unit_shift 12, unit_count 1024.
// If the receiver stalls, the result register holds; the engine waits with its
// next result and the front fills, then raises full.
module bitmap_block_allocator_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire bba_pkg::req_t                req,
	output logic                              empty,
	input  wire logic                         pop,
	output bba_pkg::rsp_t                     rsp,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_idx,
	input  wire logic [bba_pkg::ADDR_W-1:0]   cfg_wdata
);

	logic [bba_pkg::ADDR_W-1:0]  pool_base_q;
	logic [bba_pkg::SHIFT_W-1:0] unit_shift_q;
	logic [bba_pkg::CNT_W-1:0]   unit_count_q;
	bba_pkg::cfg_t               cfg;
	logic                        cmd_vld;
	logic                        cmd_pop;
	bba_pkg::cmd_t               cmd;

	// Writes to an index outside the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			unit_shift_q <= bba_pkg::SHIFT_W'(12);
			unit_count_q <= bba_pkg::CNT_W'(bba_pkg::NUM_UNITS);
		end else if (cfg_we) begin
			case (cfg_idx)
				bba_pkg::REG_POOL_BASE:  pool_base_q  <= cfg_wdata;
				bba_pkg::REG_UNIT_SHIFT: unit_shift_q <= cfg_wdata[bba_pkg::SHIFT_W-1:0];
				bba_pkg::REG_UNIT_COUNT: unit_count_q <= cfg_wdata[bba_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The usable unit count is capped at the bitmap size.
	always_comb begin
		cfg.pool_base  = pool_base_q;
		cfg.unit_shift = unit_shift_q;
		cfg.units      = (unit_count_q > bba_pkg::CNT_W'(bba_pkg::NUM_UNITS)) ?
			bba_pkg::CNT_W'(bba_pkg::NUM_UNITS) : unit_count_q;
	end

	bba_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.full    (full),
		.req     (req),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	bba_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/bba_checker.sv =====
// Port-level checks of the bitmap block allocator and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bba_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          empty,
	input wire logic          pop,
	input wire bba_pkg::rsp_t rsp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("result changed while stalled");

	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == bba_pkg::ST_OK) |-> (rsp.free_errors == '0))
		else $error("ok result carries error units");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != bba_pkg::ST_OK) |-> (rsp.result_address == '0))
		else $error("failed result carries an address");

	a_double_errs: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == bba_pkg::ST_DOUBLE) |-> (rsp.free_errors != '0))
		else $error("already-free status without error units");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rsp.status <= bba_pkg::ST_DOUBLE))
		else $error("status code out of range");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp)
);
`default_nettype wire
